// ----- rtl/ssr_pkg.sv -----
// Shared constants, register codes and types for the stream string replace block.
package ssr_pkg;

   // Fixed widths of the item fields and the configuration port
   localparam int BYTE_W      = 8;
   localparam int CNT_W       = 4;
   localparam int WIN_DEPTH   = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int LANES_W     = WIN_DEPTH * BYTE_W;

   // Longest pattern and longest replacement, in bytes
   localparam logic [CNT_W-1:0] MAX_PATTERN = CNT_W'(WIN_DEPTH);
   localparam logic [CNT_W-1:0] MAX_REPLACE = CNT_W'(8);

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MATCH_PATTERN      = 3'd0,
      REG_MATCH_LENGTH       = 3'd1,
      REG_REPLACEMENT_TEXT   = 3'd2,
      REG_REPLACEMENT_LENGTH = 3'd3,
      REG_FIRST_ONLY         = 3'd4
   } csr_reg_type;

   typedef logic [BYTE_W-1:0] data_byte_type;

   // Per-cell control: load a new byte, or take the right neighbor's byte
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage

// ----- rtl/ssr_req_if.sv -----
// Input channel: one text byte and its end mark per item.
interface ssr_req_if;
   logic                  valid;
   logic                  ready;
   ssr_pkg::data_byte_type data_byte;
   logic                  end_of_text;

   modport source (output valid, output data_byte, output end_of_text, input ready);
   modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

// ----- rtl/ssr_rsp_if.sv -----
// Result channel: one output byte, its presence flag and the end mark per item.
interface ssr_rsp_if;
   logic                  valid;
   logic                  ready;
   ssr_pkg::data_byte_type out_byte;
   logic                  byte_present;
   logic                  end_of_output;

   modport source (output valid, output out_byte, output byte_present,
                   output end_of_output, input ready);
   modport sink   (input valid, input out_byte, input byte_present,
                   input end_of_output, output ready);
endinterface

// ----- rtl/ssr_win_cell.sv -----
// Window cell: holds one pending byte and compares it against its pattern lane.
module ssr_win_cell (
   input  logic                   clock,
   input  ssr_pkg::cell_ctl_type  ctl,
   input  ssr_pkg::data_byte_type data_in,
   input  ssr_pkg::data_byte_type right_post,
   input  ssr_pkg::data_byte_type pat_byte,
   output ssr_pkg::data_byte_type post_byte,
   output logic                   match
);

   ssr_pkg::data_byte_type byte_ff;
   ssr_pkg::data_byte_type byte_in;

   // Byte as seen after the incoming item is written
   assign post_byte = ctl.load ? data_in : byte_ff;
   assign match     = (post_byte == pat_byte);

   // Advance toward the front on a miss, otherwise keep the written byte
   assign byte_in = ctl.shift ? right_post : post_byte;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

// ----- rtl/ssr_out_cell.sv -----
// Output cell: holds one byte of a result burst and hands it toward the port.
module ssr_out_cell (
   input  logic                   clock,
   input  ssr_pkg::cell_ctl_type  ctl,
   input  ssr_pkg::data_byte_type load_byte,
   input  ssr_pkg::data_byte_type right_byte,
   output ssr_pkg::data_byte_type byte_out
);

   ssr_pkg::data_byte_type byte_ff;
   ssr_pkg::data_byte_type byte_in;

   // Load a fresh burst, advance on emit, otherwise hold
   always_comb begin
      byte_in = byte_ff;
      if (ctl.load) begin
         byte_in = load_byte;
      end else if (ctl.shift) begin
         byte_in = right_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign byte_out = byte_ff;

endmodule

// ----- rtl/stream_string_replace.sv -----
// Top level: streaming search and replace over a chain of window and output cells.
//
//   channel   direction  handshake       payload
//   req_if    in         valid/ready     data_byte[7:0], end_of_text
//   rsp_if    out        valid/ready     out_byte[7:0], byte_present, end_of_output
//   csr_*     in         write enable    csr_index[2:0], csr_write_data[63:0]
//
// The window decision for an input byte is made in the cycle it is taken, and the resulting
// burst (0 to 8 bytes, or a bare end mark) waits in a one-burst holding register.
// The output cell chain sends one result per cycle while rsp_if is ready, so sustained rate is one
// byte per cycle until a replacement longer than the pattern or an end-of-text flush makes it the limit.
// Synchronous active-high reset clears counts and valid flags; registers take their defaults.
// A stalled result holds in the output chain; input is taken while the holding slot is free.
module stream_string_replace (
   input  logic                                 clock,
   input  logic                                 reset,
   ssr_req_if.sink                              req_if,
   ssr_rsp_if.source                            rsp_if,
   input  logic                                 csr_write_en,
   input  logic [ssr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ssr_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   localparam int N = ssr_pkg::WIN_DEPTH;
   localparam int CW = ssr_pkg::CNT_W;
   localparam int BW = ssr_pkg::BYTE_W;

   // Configuration registers
   logic [ssr_pkg::LANES_W-1:0] pattern_ff;
   logic [CW-1:0]               mlen_ff;
   logic [ssr_pkg::LANES_W-1:0] repl_ff;
   logic [CW-1:0]               rlen_ff;
   logic                        first_ff;

   // Window control state
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;

   // Holding slot for one burst
   logic                   p_valid_ff, p_valid_in;
   ssr_pkg::data_byte_type p_bytes_ff [N];
   logic [CW-1:0]          p_cnt_ff;
   logic                   p_present_ff;
   logic                   p_eot_ff;

   // Output chain state
   logic [CW-1:0] o_cnt_ff, o_cnt_in;
   logic          o_present_ff;
   logic          o_eot_ff;

   ssr_pkg::data_byte_type win_post [N];
   logic [N-1:0]           win_match;
   ssr_pkg::cell_ctl_type  win_ctl [N];
   ssr_pkg::data_byte_type out_byte_q [N];
   ssr_pkg::cell_ctl_type  out_ctl;

   logic          accept, last, bypass, decide, hit;
   logic [CW-1:0] eff_len, rep_len, post_cnt, burst_len;
   logic [N-1:0]  len_mask;
   ssr_pkg::data_byte_type burst_bytes [N];
   logic          emit, o_free, move, csr_listed;

   // Clamp configured lengths
   always_comb begin
      if (mlen_ff == '0) begin
         eff_len = CW'(1);
      end else if (mlen_ff > ssr_pkg::MAX_PATTERN) begin
         eff_len = ssr_pkg::MAX_PATTERN;
      end else begin
         eff_len = mlen_ff;
      end
      rep_len = (rlen_ff > ssr_pkg::MAX_REPLACE) ? ssr_pkg::MAX_REPLACE : rlen_ff;
      for (int k = 0; k < N; k++) begin
         len_mask[k] = (CW'(k) < eff_len);
      end
   end

   // Handshakes
   assign emit          = rsp_if.valid && rsp_if.ready;
   assign o_free        = (o_cnt_ff == '0) || ((o_cnt_ff == CW'(1)) && emit);
   assign move          = p_valid_ff && o_free;
   assign req_if.ready  = !p_valid_ff || move;
   assign accept        = req_if.valid && req_if.ready;
   assign last          = req_if.end_of_text;

   // Window cells
   for (genvar k = 0; k < N; k++) begin : g_win
      ssr_pkg::data_byte_type right;
      if (k == N - 1) begin : g_tail
         assign right = '0;
      end else begin : g_body
         assign right = win_post[k+1];
      end

      assign win_ctl[k].load  = accept && !bypass && (cnt_ff == CW'(k));
      assign win_ctl[k].shift = accept && decide && !hit;

      ssr_win_cell u_cell (
         .clock      (clock),
         .ctl        (win_ctl[k]),
         .data_in    (req_if.data_byte),
         .right_post (right),
         .pat_byte   (pattern_ff[k*BW +: BW]),
         .post_byte  (win_post[k]),
         .match      (win_match[k])
      );
   end

   // Decide on the window and build the burst for this item
   always_comb begin
      bypass   = first_ff && done_ff;
      post_cnt = cnt_ff + CW'(1);
      decide   = !bypass && (post_cnt >= eff_len);
      hit      = decide && ((win_match | ~len_mask) == '1);
      burst_bytes = win_post;
      if (bypass) begin
         burst_bytes[0] = req_if.data_byte;
         burst_len      = CW'(1);
      end else if (hit) begin
         for (int k = 0; k < N; k++) begin
            burst_bytes[k] = repl_ff[k*BW +: BW];
         end
         burst_len = rep_len;
      end else if (decide) begin
         burst_len = last ? eff_len : CW'(1);
      end else begin
         burst_len = last ? post_cnt : '0;
      end
   end

   // Window count and replaced flag
   always_comb begin
      cnt_in  = cnt_ff;
      done_in = done_ff;
      if (csr_write_en && csr_listed) begin
         cnt_in  = '0;
         done_in = 1'b0;
      end else if (accept) begin
         if (hit) begin
            cnt_in  = '0;
            done_in = 1'b1;
         end else if (decide) begin
            cnt_in = eff_len - CW'(1);
         end else if (!bypass) begin
            cnt_in = post_cnt;
         end
         if (last) begin
            cnt_in  = '0;
            done_in = 1'b0;
         end
      end
   end

   always_comb begin
      case (csr_index)
         ssr_pkg::REG_MATCH_PATTERN,
         ssr_pkg::REG_MATCH_LENGTH,
         ssr_pkg::REG_REPLACEMENT_TEXT,
         ssr_pkg::REG_REPLACEMENT_LENGTH,
         ssr_pkg::REG_FIRST_ONLY: csr_listed = 1'b1;
         default:                 csr_listed = 1'b0;
      endcase
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         mlen_ff    <= CW'(1);
         repl_ff    <= '0;
         rlen_ff    <= '0;
         first_ff   <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            ssr_pkg::REG_MATCH_PATTERN:      pattern_ff <= csr_write_data;
            ssr_pkg::REG_MATCH_LENGTH:       mlen_ff    <= csr_write_data[CW-1:0];
            ssr_pkg::REG_REPLACEMENT_TEXT:   repl_ff    <= csr_write_data;
            ssr_pkg::REG_REPLACEMENT_LENGTH: rlen_ff    <= csr_write_data[CW-1:0];
            ssr_pkg::REG_FIRST_ONLY:         first_ff   <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Window control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   // Holding slot: fill on an item with results, drain into the output chain
   assign p_valid_in = (accept && ((burst_len != '0) || last)) ? 1'b1 :
                       (move ? 1'b0 : p_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p_bytes_ff   <= burst_bytes;
         p_cnt_ff     <= (burst_len == '0) ? CW'(1) : burst_len;
         p_present_ff <= (burst_len != '0);
         p_eot_ff     <= last;
      end
   end

   // Output cell chain
   assign out_ctl.load  = move;
   assign out_ctl.shift = emit;

   for (genvar k = 0; k < N; k++) begin : g_out
      ssr_pkg::data_byte_type right;
      if (k == N - 1) begin : g_tail
         assign right = '0;
      end else begin : g_body
         assign right = out_byte_q[k+1];
      end

      ssr_out_cell u_cell (
         .clock      (clock),
         .ctl        (out_ctl),
         .load_byte  (p_bytes_ff[k]),
         .right_byte (right),
         .byte_out   (out_byte_q[k])
      );
   end

   always_comb begin
      o_cnt_in = o_cnt_ff;
      if (move) begin
         o_cnt_in = p_cnt_ff;
      end else if (emit) begin
         o_cnt_in = o_cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_cnt_ff <= '0;
      end else begin
         o_cnt_ff <= o_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         o_present_ff <= p_present_ff;
         o_eot_ff     <= p_eot_ff;
      end
   end

   // Result port
   assign rsp_if.valid         = (o_cnt_ff != '0);
   assign rsp_if.out_byte      = o_present_ff ? out_byte_q[0] : '0;
   assign rsp_if.byte_present  = o_present_ff;
   assign rsp_if.end_of_output = o_eot_ff && (o_cnt_ff == CW'(1));

`ifndef ASSERT_OFF
   // The window never holds a full pattern between items
   a_cnt_below_len: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < eff_len)
      else $error("window count reached pattern length");

   // After the single replacement the window stays empty
   a_bypass_empty: assert property (@(posedge clock) disable iff (reset)
      (first_ff && done_ff) |-> (cnt_ff == '0))
      else $error("window holds bytes in pass-through mode");

   // A bare end mark is a single result that carries the end
   a_bare_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !o_present_ff) |-> ((o_cnt_ff == CW'(1)) && o_eot_ff))
      else $error("bare result without end mark");

   // A waiting burst is never dropped before the output chain takes it
   a_slot_hold: assert property (@(posedge clock) disable iff (reset)
      (p_valid_ff && !move) |=> p_valid_ff)
      else $error("held burst lost");
`endif

endmodule
